/* sv/huffman_table_encoder_core_defines.svh */
// ---------------------------------------------------------------------------
// huffman table encoder assertion macros
// shared property forms, sampled on the block clock, off during reset
// ---------------------------------------------------------------------------
`ifndef HUFFMAN_TABLE_ENCODER_CORE_DEFINES_SVH
`define HUFFMAN_TABLE_ENCODER_CORE_DEFINES_SVH

// same-cycle implication
`define HTE_ASSERT_IMP(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication
`define HTE_ASSERT_NXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

/* sv/hte_pkg.sv */
// ---------------------------------------------------------------------------
// hte_pkg
// types and fixed constants of the huffman table encoder
// ---------------------------------------------------------------------------
package hte_pkg;

   localparam logic [1:0] REQ_LOAD   = 2'd0;
   localparam logic [1:0] REQ_ENCODE = 2'd1;
   localparam logic [1:0] REQ_END    = 2'd2;

   localparam int BYTE_BITS = 8;
   localparam int PEND_BITS = 7;
   localparam int END_PAD   = 7;
   localparam int FIELD_CODE_W = 25;
   localparam int FIELD_LEN_W  = 5;

   localparam int QUEUE_DEPTH = 4;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   typedef struct packed {
      logic [1:0]              req_type;
      logic [7:0]              symbol;
      logic [FIELD_CODE_W-1:0] code_word;
      logic [FIELD_LEN_W-1:0]  code_length;
   } hte_req_type;

   typedef struct packed {
      logic [7:0] out_byte;
      logic       last_of_run;
      logic       end_of_string;
   } hte_rsp_type;

   typedef struct packed {
      logic [QCNT_W-1:0] count;
      logic              not_empty;
   } hte_qstat_type;

endpackage

/* sv/huffman_table_encoder_core.sv */
// ---------------------------------------------------------------------------
// huffman_table_encoder_core
// table driven huffman encoder, codes packed lsb first into bytes
// ---------------------------------------------------------------------------
// req channel: one word per item, load a table entry, encode a byte or end
// the string. rsp channel: one compressed byte per word, with a mark on the
// last byte of each item and on the last byte of the string.
// a load writes the table and gives nothing. an encode or end word goes
// through the table lookup stage register, a four entry queue, the packer
// work register and the output register before its first byte is valid.
// throughput is one item per cycle while items give at most one byte each
// and rsp is not stalled; an item that gives more bytes holds the packer
// until they are out, one byte a cycle from the output register.
// when rsp is stalled the output byte holds, the packer waits and the queue
// fills; req_stall rises once the queue and lookup stage hold four words.
// reset clears the pending bits and all handshake state; table entries stay
// undefined until loaded and need no clearing pass.
// ---------------------------------------------------------------------------
module huffman_table_encoder_core import hte_pkg::*; #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 25
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  hte_req_type req_data,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output hte_rsp_type rsp_data
);

   localparam int LEN_SAT = (MAX_CODE_LEN < 31) ? MAX_CODE_LEN : 31;
   localparam int CODE_W  = (MAX_CODE_LEN < 25) ? MAX_CODE_LEN : 25;
   localparam int QE_W    = 1 + $clog2(LEN_SAT + 8) + CODE_W;

   hte_qstat_type   qstat;
   logic            push;
   logic            pop;
   logic [QE_W-1:0] push_data;
   logic [QE_W-1:0] pop_data;

   hte_front #(
      .SYMBOL_COUNT(SYMBOL_COUNT),
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .qstat     (qstat),
      .push      (push),
      .push_data (push_data)
   );

   hte_queue #(
      .WIDTH(QE_W)
   ) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_data),
      .pop       (pop),
      .pop_data  (pop_data),
      .qstat     (qstat)
   );

   hte_back #(
      .MAX_CODE_LEN(MAX_CODE_LEN)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .qstat     (qstat),
      .pop_data  (pop_data),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

/* sv/hte_queue.sv */
// ---------------------------------------------------------------------------
// hte_queue
// short fifo between the lookup front and the bit packing back
// ---------------------------------------------------------------------------
module hte_queue import hte_pkg::*; #(
   parameter int WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output hte_qstat_type    qstat
);

   logic [WIDTH-1:0]  slot_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0] count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      case ({push, pop})
         2'b10:   count_in = count_ff + QCNT_W'(1);
         2'b01:   count_in = count_ff - QCNT_W'(1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         slot_ff[wr_ptr_ff] <= push_data;
      end
   end

   assign pop_data        = slot_ff[rd_ptr_ff];
   assign qstat.count     = count_ff;
   assign qstat.not_empty = (count_ff != '0);

endmodule

/* sv/hte_front.sv */
// ---------------------------------------------------------------------------
// hte_front
// accepts words, keeps the code table and looks up codes for the back
// ---------------------------------------------------------------------------
`include "huffman_table_encoder_core_defines.svh"

module hte_front import hte_pkg::*; #(
   parameter int SYMBOL_COUNT = 256,
   parameter int MAX_CODE_LEN = 25
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   input  hte_req_type        req_data,
   input  hte_qstat_type      qstat,
   output logic               push,
   output logic [((MAX_CODE_LEN < 25) ? MAX_CODE_LEN : 25)
                 + $clog2(((MAX_CODE_LEN < 31) ? MAX_CODE_LEN : 31) + 8) : 0] push_data
);

   localparam int LEN_SAT = (MAX_CODE_LEN < 31) ? MAX_CODE_LEN : 31;
   localparam int CODE_W  = (MAX_CODE_LEN < 25) ? MAX_CODE_LEN : 25;
   localparam int LEN_W   = $clog2(LEN_SAT + 1);
   localparam int QLEN_W  = $clog2(LEN_SAT + 8);
   localparam int IDX_W   = $clog2(SYMBOL_COUNT);

   logic [CODE_W-1:0] code_mem [SYMBOL_COUNT];
   logic [LEN_W-1:0]  len_mem  [SYMBOL_COUNT];

   logic [CODE_W-1:0] rd_code_ff;
   logic [LEN_W-1:0]  rd_len_ff;
   logic [LEN_W-1:0]  len0_ff;
   logic              s1_valid_ff, s1_valid_in;
   logic              s1_end_ff;
   logic [LEN_W-1:0]  s1_len0_ff;

   logic                    accept;
   logic                    in_range;
   logic [IDX_W-1:0]        idx;
   logic                    do_load;
   logic [FIELD_LEN_W-1:0]  len_sat;
   logic [FIELD_CODE_W-1:0] code_mask;
   logic [CODE_W-1:0]       wr_code;
   logic [LEN_W-1:0]        wr_len;
   logic [QCNT_W:0]         occupancy;
   logic [QLEN_W-1:0]       q_len;

   // room is counted for the word already in the lookup stage
   assign occupancy = {1'b0, qstat.count} + {{QCNT_W{1'b0}}, s1_valid_ff};
   assign req_stall = (occupancy >= (QCNT_W + 1)'(QUEUE_DEPTH));
   assign accept    = req_valid && !req_stall;

   assign in_range = ({1'b0, req_data.symbol} < 9'(SYMBOL_COUNT));
   assign idx      = req_data.symbol[IDX_W-1:0];

   always_comb begin
      len_sat   = (req_data.code_length > FIELD_LEN_W'(LEN_SAT)) ?
                  FIELD_LEN_W'(LEN_SAT) : req_data.code_length;
      code_mask = (FIELD_CODE_W'(1) << len_sat) - FIELD_CODE_W'(1);
      wr_code   = CODE_W'(req_data.code_word & code_mask);
      wr_len    = LEN_W'(len_sat);
      do_load   = 1'b0;
      s1_valid_in = 1'b0;
      if (accept) begin
         unique case (req_data.req_type)
            REQ_LOAD:   do_load = in_range;
            REQ_ENCODE: s1_valid_in = in_range;
            REQ_END:    s1_valid_in = 1'b1;
            default:    s1_valid_in = 1'b0;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (do_load) begin
         code_mem[idx] <= wr_code;
         len_mem[idx]  <= wr_len;
      end
      rd_code_ff <= code_mem[idx];
      rd_len_ff  <= len_mem[idx];
   end

   // copy of entry 0 length for end words
   always_ff @(posedge clock) begin
      if (do_load && (idx == '0)) begin
         len0_ff <= wr_len;
      end
      s1_end_ff  <= (req_data.req_type == REQ_END);
      s1_len0_ff <= len0_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   assign q_len = s1_end_ff ? (QLEN_W'(s1_len0_ff) + QLEN_W'(END_PAD)) : QLEN_W'(rd_len_ff);

   assign push      = s1_valid_ff;
   assign push_data = {s1_end_ff, q_len, s1_end_ff ? {CODE_W{1'b0}} : rd_code_ff};

   `HTE_ASSERT_IMP(a_queue_room, s1_valid_ff, qstat.count < QCNT_W'(QUEUE_DEPTH), "queue overflow")
   `HTE_ASSERT_NXT(a_end_forwarded, accept && (req_data.req_type == REQ_END), s1_valid_ff && s1_end_ff, "end word lost")

endmodule

/* sv/hte_back.sv */
// ---------------------------------------------------------------------------
// hte_back
// packs codes above the pending bits and sends out one byte a cycle while rsp is not stalled
// ---------------------------------------------------------------------------
`include "huffman_table_encoder_core_defines.svh"

module hte_back import hte_pkg::*; #(
   parameter int MAX_CODE_LEN = 25
) (
   input  logic          clock,
   input  logic          reset,
   input  hte_qstat_type qstat,
   input  logic [((MAX_CODE_LEN < 25) ? MAX_CODE_LEN : 25)
                 + $clog2(((MAX_CODE_LEN < 31) ? MAX_CODE_LEN : 31) + 8) : 0] pop_data,
   output logic          pop,
   output logic          rsp_valid,
   input  logic          rsp_stall,
   output hte_rsp_type   rsp_data
);

   localparam int LEN_SAT = (MAX_CODE_LEN < 31) ? MAX_CODE_LEN : 31;
   localparam int CODE_W  = (MAX_CODE_LEN < 25) ? MAX_CODE_LEN : 25;
   localparam int QLEN_W  = $clog2(LEN_SAT + 8);
   localparam int STAGE_W = PEND_BITS + CODE_W;
   localparam int CNT_W   = $clog2(LEN_SAT + PEND_BITS + END_PAD + 1);

   logic [STAGE_W-1:0] wbits_ff, wbits_in;
   logic [CNT_W-1:0]   wcnt_ff, wcnt_in;
   logic               wend_ff, wend_in;
   logic               rsp_valid_ff, rsp_valid_in;
   hte_rsp_type        rsp_word_ff, rsp_word_in;

   logic                 slot_free;
   logic                 emit;
   logic                 done;
   logic [STAGE_W-1:0]   rem_bits;
   logic [CNT_W-1:0]     rem_cnt;
   logic [PEND_BITS-1:0] pend_bits;
   logic [2:0]           pend_cnt;
   logic                 q_end;
   logic [QLEN_W-1:0]    q_len;
   logic [CODE_W-1:0]    q_code;

   assign {q_end, q_len, q_code} = pop_data;

   always_comb begin
      slot_free = !rsp_valid_ff || !rsp_stall;
      emit      = (wcnt_ff >= CNT_W'(BYTE_BITS)) && slot_free;
      rem_bits  = emit ? (wbits_ff >> BYTE_BITS) : wbits_ff;
      rem_cnt   = emit ? (wcnt_ff - CNT_W'(BYTE_BITS)) : wcnt_ff;
      done      = (rem_cnt < CNT_W'(BYTE_BITS));
      // an end word drops its leftover bits
      pend_bits = wend_ff ? '0 : rem_bits[PEND_BITS-1:0];
      pend_cnt  = wend_ff ? '0 : rem_cnt[2:0];
      pop       = done && qstat.not_empty;

      if (!done) begin
         wbits_in = rem_bits;
         wcnt_in  = rem_cnt;
         wend_in  = wend_ff;
      end else if (pop) begin
         wbits_in = STAGE_W'(pend_bits) | (STAGE_W'(q_code) << pend_cnt);
         wcnt_in  = CNT_W'(pend_cnt) + CNT_W'(q_len);
         wend_in  = q_end;
      end else begin
         wbits_in = STAGE_W'(pend_bits);
         wcnt_in  = CNT_W'(pend_cnt);
         wend_in  = 1'b0;
      end

      rsp_word_in.out_byte      = wbits_ff[BYTE_BITS-1:0];
      rsp_word_in.last_of_run   = done;
      rsp_word_in.end_of_string = done && wend_ff;
      rsp_valid_in = emit || (rsp_valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wbits_ff     <= '0;
         wcnt_ff      <= '0;
         wend_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         wbits_ff     <= wbits_in;
         wcnt_ff      <= wcnt_in;
         wend_ff      <= wend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         rsp_word_ff <= rsp_word_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_word_ff;

   `HTE_ASSERT_IMP(a_eos_is_last, rsp_valid_ff, !rsp_word_ff.end_of_string || rsp_word_ff.last_of_run, "end mark without last mark")
   `HTE_ASSERT_NXT(a_idle_settles, done && !pop, !wend_ff && (wcnt_ff < CNT_W'(BYTE_BITS)), "work register not settled")
   `HTE_ASSERT_IMP(a_count_bound, 1'b1, wcnt_ff <= CNT_W'(LEN_SAT + PEND_BITS + END_PAD), "bit count overrun")

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_top
// self-checking bench for the huffman table encoder core: loads code entries,
// encodes bytes, sends unused words and closes strings under random valid and stall gaps, and
// compares every output byte and its marks with a bit-level packer model
// ---------------------------------------------------------------------------
module tb_top;
   import hte_pkg::*;

   localparam int SYMBOL_COUNT   = 256;
   localparam int MAX_CODE_LEN   = 25;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES   = 16;
   localparam int PHASE_ITEMS    = 105;
   localparam logic [1:0] REQ_UNUSED = 2'd3;

   // -------------------------------------------------------------------------
   // scoreboard: mirrors the code store and the pending bits, keeps the bytes
   // still due from the block
   // -------------------------------------------------------------------------
   class encoded_byte_board;
      logic [FIELD_CODE_W-1:0] code_mirror [SYMBOL_COUNT];
      logic [FIELD_LEN_W-1:0]  len_mirror  [SYMBOL_COUNT];
      logic [PEND_BITS-1:0]    carry_bits;
      int unsigned             carry_count;
      hte_rsp_type             due_bytes [$];
      int                      mismatches;
      int                      bytes_seen;
      int                      strings_closed;

      function new();
         carry_bits     = '0;
         carry_count    = 0;
         mismatches     = 0;
         bytes_seen     = 0;
         strings_closed = 0;
      endfunction

      // split the staged bits into full bytes, earliest bits first
      function void pack_bytes(logic [39:0] stage, int unsigned count, bit closing);
         int unsigned n;
         hte_rsp_type b;
         n = count / BYTE_BITS;
         for (int i = 0; i < n; i++) begin
            b.out_byte      = stage[7:0];
            b.last_of_run   = (i == n - 1);
            b.end_of_string = closing && (i == n - 1);
            due_bytes.push_back(b);
            stage = stage >> BYTE_BITS;
         end
         carry_bits  = closing ? '0 : stage[PEND_BITS-1:0];
         carry_count = closing ? 0 : count % BYTE_BITS;
      endfunction

      // note one accepted request word and queue the bytes it causes
      function void encode_word(hte_req_type w);
         logic [39:0] stage;
         logic [31:0] keep;
         int unsigned count;
         int unsigned len;
         stage = 40'(carry_bits);
         count = carry_count;
         case (w.req_type)
            REQ_LOAD: begin
               len = (w.code_length > MAX_CODE_LEN) ? MAX_CODE_LEN : w.code_length;
               keep = (32'd1 << len) - 32'd1;
               code_mirror[w.symbol] = w.code_word & keep[FIELD_CODE_W-1:0];
               len_mirror[w.symbol]  = len[FIELD_LEN_W-1:0];
            end
            REQ_ENCODE: begin
               stage = stage | (40'(code_mirror[w.symbol]) << count);
               pack_bytes(stage, count + len_mirror[w.symbol], 1'b0);
            end
            REQ_END: begin
               // the end code is entry zero's length of zero bits, then pad to flush
               pack_bytes(stage, count + len_mirror[0] + END_PAD, 1'b1);
            end
            default: ;
         endcase
      endfunction

      task flag_mismatch(string what, int got, int want);
         mismatches++;
         $display("[%0t] mismatch on %s: got %0h, want %0h (byte %0d)",
                  $time, what, got, want, bytes_seen);
      endtask

      task match_byte(hte_rsp_type got);
         hte_rsp_type want;
         bytes_seen++;
         if (got.end_of_string)
            strings_closed++;
         if (due_bytes.size() == 0) begin
            flag_mismatch("unexpected byte", got.out_byte, 0);
            return;
         end
         want = due_bytes.pop_front();
         if (got.out_byte !== want.out_byte)
            flag_mismatch("out_byte", got.out_byte, want.out_byte);
         if (got.last_of_run !== want.last_of_run)
            flag_mismatch("last_of_run", got.last_of_run, want.last_of_run);
         if (got.end_of_string !== want.end_of_string)
            flag_mismatch("end_of_string", got.end_of_string, want.end_of_string);
      endtask
   endclass

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   hte_req_type req_data = '0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   hte_rsp_type rsp_data;

   encoded_byte_board board;

   int          send_idle_pct = 22;
   int          rsp_idle_pct  = 84;
   int          quiet_cycles  = 0;
   bit          entry_ready [SYMBOL_COUNT];
   logic [7:0]  ready_list [$];
   int          loads_sent    = 0;
   int          encodes_sent  = 0;
   int          ends_sent     = 0;
   int          ignored_sent  = 0;

   huffman_table_encoder_core #(
      .SYMBOL_COUNT (SYMBOL_COUNT),
      .MAX_CODE_LEN (MAX_CODE_LEN)
   ) u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // receiver side stall
   always @(posedge clock) begin
      rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
   end

   // byte checker, values sampled before the edge updates
   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall)
         board.match_byte(rsp_data);
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
   end

   initial begin
      wait (quiet_cycles >= WATCHDOG_LIMIT);
      $display("[%0t] no word moved for %0d cycles", $time, WATCHDOG_LIMIT);
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic send_word(hte_req_type w);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data  <= w;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      board.encode_word(w);
   endtask

   task automatic load_entry(logic [7:0] sym, logic [FIELD_CODE_W-1:0] code,
                             logic [FIELD_LEN_W-1:0] len);
      hte_req_type w;
      w.req_type    = REQ_LOAD;
      w.symbol      = sym;
      w.code_word   = code;
      w.code_length = len;
      send_word(w);
      loads_sent++;
      if (!entry_ready[sym]) begin
         entry_ready[sym] = 1'b1;
         ready_list.push_back(sym);
      end
   endtask

   // only loaded entries are ever encoded
   task automatic encode_symbol(logic [7:0] sym);
      hte_req_type w;
      w.req_type    = REQ_ENCODE;
      w.symbol      = sym;
      w.code_word   = FIELD_CODE_W'($urandom());
      w.code_length = FIELD_LEN_W'($urandom());
      send_word(w);
      encodes_sent++;
   endtask

   task automatic close_string();
      hte_req_type w;
      w.req_type    = REQ_END;
      w.symbol      = 8'($urandom());
      w.code_word   = FIELD_CODE_W'($urandom());
      w.code_length = FIELD_LEN_W'($urandom());
      send_word(w);
      ends_sent++;
   endtask

   task automatic send_unused(logic [FIELD_CODE_W-1:0] code);
      hte_req_type w;
      w.req_type    = REQ_UNUSED;
      w.symbol      = 8'($urandom());
      w.code_word   = code;
      w.code_length = FIELD_LEN_W'($urandom());
      send_word(w);
      ignored_sent++;
   endtask

   task automatic random_item();
      int pick;
      logic [FIELD_LEN_W-1:0] len;
      if ($urandom_range(99) < 3)
         send_unused(FIELD_CODE_W'($urandom()));
      pick = $urandom_range(99);
      if (pick < 15) begin
         // mostly short codes so the byte rate keeps up, a few long or overlong
         len = ($urandom_range(99) < 80) ? FIELD_LEN_W'($urandom_range(1, 9))
                                         : FIELD_LEN_W'($urandom_range(0, 31));
         load_entry(($urandom_range(1) == 0) ? 8'($urandom_range(0, 15)) : 8'($urandom()),
                    FIELD_CODE_W'($urandom()), len);
      end else if (pick < 91) begin
         encode_symbol(ready_list[$urandom_range(0, ready_list.size() - 1)]);
      end else begin
         close_string();
      end
   endtask

   initial begin
      board = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // directed: table extremes, masking, saturation, empty and long ends
      load_entry(8'd0, '0, 5'd3);
      load_entry(8'd255, '1, 5'd25);
      load_entry(8'd1, '1, 5'd31);
      load_entry(8'd2, '1, 5'd3);
      load_entry(8'd3, '1, 5'd0);
      send_unused('1);
      encode_symbol(8'd3);
      encode_symbol(8'd2);
      encode_symbol(8'd255);
      encode_symbol(8'd1);
      encode_symbol(8'd255);
      encode_symbol(8'd255);
      encode_symbol(8'd255);
      close_string();
      close_string();
      load_entry(8'd0, '0, 5'd0);
      close_string();
      encode_symbol(8'd2);
      close_string();
      load_entry(8'd0, '0, 5'd25);
      encode_symbol(8'd1);
      encode_symbol(8'd2);
      encode_symbol(8'd255);
      close_string();

      repeat (PHASE_ITEMS) random_item();
      send_idle_pct = 84;
      rsp_idle_pct  = 22;
      repeat (PHASE_ITEMS) random_item();
      send_idle_pct = 0;
      rsp_idle_pct  = 0;
      repeat (PHASE_ITEMS) random_item();
      req_valid <= 1'b0;

      while (board.due_bytes.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (board.due_bytes.size() != 0)
         board.flag_mismatch("bytes never produced", board.due_bytes.size(), 0);

      $display("sent %0d loads, %0d encodes, %0d string ends, %0d unused requests",
               loads_sent, encodes_sent, ends_sent, ignored_sent);
      $display("checked %0d bytes over %0d closed strings, %0d mismatches",
               board.bytes_seen, board.strings_closed, board.mismatches);
      if (board.mismatches == 0)
         $display("Testbench completed without errors");
      else
         $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
